### rtl/lbcs_pkg.sv
// Shared types and constants for the LED blink-code sequencer.
// Used by lbcs_timer, lbcs_seq and led_blink_code_sequencer_core; no dependencies.
`default_nettype none

package lbcs_pkg;

    localparam int TIME_W  = 16;
    localparam int BLINK_W = 8;
    localparam int TEST_W  = 2;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_NORMAL_ON   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_NORMAL_OFF  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_NORMAL_BLNK = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_ERROR_ON    = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ERROR_OFF   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_ERROR_BLNK  = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_LONG_OFF    = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_TEST_MODE   = 3'd7;

    // Reset values
    localparam logic [TIME_W-1:0]  RST_NORMAL_ON   = 16'd0;
    localparam logic [TIME_W-1:0]  RST_NORMAL_OFF  = 16'd100;
    localparam logic [BLINK_W-1:0] RST_NORMAL_BLNK = 8'd1;
    localparam logic [TIME_W-1:0]  RST_ERROR_ON    = 16'd100;
    localparam logic [TIME_W-1:0]  RST_ERROR_OFF   = 16'd100;
    localparam logic [BLINK_W-1:0] RST_ERROR_BLNK  = 8'd2;
    localparam logic [TIME_W-1:0]  RST_LONG_OFF    = 16'd1000;

    // Test mode codes; bit 1 gives the forced level
    localparam logic [TEST_W-1:0] TEST_NONE  = 2'd0;
    localparam logic [TEST_W-1:0] TEST_FORCE_OFF = 2'd1;
    localparam logic [TEST_W-1:0] TEST_FORCE_ON  = 2'd2;

    // Item kinds (tuser)
    localparam logic OP_POLL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Latched mode codes
    localparam logic [1:0] MODE_INITIAL = 2'd0;
    localparam logic [1:0] MODE_NORMAL  = 2'd1;
    localparam logic [1:0] MODE_FAULT   = 2'd2;

    typedef enum logic [3:0] {
        TOP_IDLE       = 4'b0001,
        TOP_START      = 4'b0010,
        TOP_START_WAIT = 4'b0100,
        TOP_OPERATE    = 4'b1000
    } top_phase_t;

    typedef enum logic [4:0] {
        BL_IDLE      = 5'b00001,
        BL_LED_ON    = 5'b00010,
        BL_ON_WAIT   = 5'b00100,
        BL_OFF_WAIT  = 5'b01000,
        BL_LONG_WAIT = 5'b10000
    } blink_phase_t;

    typedef struct packed {
        logic [TIME_W-1:0]  normal_on_ms;
        logic [TIME_W-1:0]  normal_off_ms;
        logic [BLINK_W-1:0] normal_blinks;
        logic [TIME_W-1:0]  error_on_ms;
        logic [TIME_W-1:0]  error_off_ms;
        logic [BLINK_W-1:0] error_blinks;
        logic [TIME_W-1:0]  long_off_ms;
        logic [TEST_W-1:0]  test_mode;
    } cfg_t;

    typedef struct packed {
        logic              tick;
        logic              load;
        logic [TIME_W-1:0] value;
    } tmr_ctl_t;

endpackage

`default_nettype wire

### rtl/lbcs_timer.sv
// Millisecond down-counter with done flag for the blink-code sequencer.
// Depends on lbcs_pkg (tmr_ctl_t, TIME_W).
`default_nettype none

module lbcs_timer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lbcs_pkg::tmr_ctl_t ctl,
    output logic                   done
);
    import lbcs_pkg::*;

    logic [TIME_W-1:0] count_reg, count_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] count_dec;

    assign count_dec = count_reg - TIME_W'(1);

    // Load wins; a tick only moves a nonzero count
    always_comb begin
        count_next = count_reg;
        done_next  = done_reg;
        if (ctl.load) begin
            count_next = ctl.value;
            done_next  = (ctl.value == '0);
        end else if (ctl.tick && count_reg != '0) begin
            count_next = count_dec;
            done_next  = (count_dec == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    a_done_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> count_reg == '0)
        else $error("timer done with nonzero count");

    a_load_clears_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load && ctl.value != '0 |=> !done_reg)
        else $error("timer done right after nonzero load");

    a_last_tick_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.tick && !ctl.load && count_reg == TIME_W'(1) |=> done_reg)
        else $error("timer did not finish on last tick");

endmodule

`default_nettype wire

### rtl/lbcs_seq.sv
// Power-up and blink-code state machines, mode latch and LED register.
// Depends on lbcs_pkg; drives lbcs_timer through a tmr_ctl_t.
`default_nettype none

module lbcs_seq #(
    parameter int START_TIME_MS = 50
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic               op,
    input  wire logic               fault,
    input  wire lbcs_pkg::cfg_t     cfg,
    input  wire logic               tmr_done,
    output lbcs_pkg::tmr_ctl_t      tmr_ctl,
    output logic                    led_level
);
    import lbcs_pkg::*;

    top_phase_t         top_reg, top_next;
    blink_phase_t       bl_reg, bl_next;
    logic [BLINK_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [1:0]         mode_reg, mode_next, mode_sel;
    logic [TIME_W-1:0]  on_reg, on_next, off_reg, off_next, long_reg, long_next;
    logic [BLINK_W-1:0] blinks_reg, blinks_next;
    logic               led_reg, led_next;
    logic               poll, mode_chg;

    assign poll     = step && (op == OP_POLL) && (cfg.test_mode == TEST_NONE);
    assign mode_sel = fault ? MODE_FAULT : MODE_NORMAL;
    assign mode_chg = (mode_sel != mode_reg);
    assign cnt_inc  = cnt_reg + BLINK_W'(1);

    // Mode latch: a new mode takes effect within the same poll
    always_comb begin
        mode_next   = mode_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        blinks_next = blinks_reg;
        long_next   = long_reg;
        if (poll && top_reg == TOP_OPERATE && mode_chg) begin
            mode_next = mode_sel;
            long_next = cfg.long_off_ms;
            if (fault) begin
                on_next     = cfg.error_on_ms;
                off_next    = cfg.error_off_ms;
                blinks_next = cfg.error_blinks;
            end else begin
                on_next     = cfg.normal_on_ms;
                off_next    = cfg.normal_off_ms;
                blinks_next = cfg.normal_blinks;
            end
        end
    end

    // Phase machines and timer requests
    always_comb begin
        top_next      = top_reg;
        bl_next       = bl_reg;
        cnt_next      = cnt_reg;
        led_next      = led_reg;
        tmr_ctl.tick  = step && (op == OP_TICK);
        tmr_ctl.load  = 1'b0;
        tmr_ctl.value = on_next;
        if (poll) begin
            unique case (top_reg)
                TOP_IDLE: begin
                    led_next = 1'b1;
                    top_next = TOP_START;
                end
                TOP_START: begin
                    led_next      = 1'b1;
                    tmr_ctl.load  = 1'b1;
                    tmr_ctl.value = TIME_W'(START_TIME_MS);
                    top_next      = TOP_START_WAIT;
                end
                TOP_START_WAIT: begin
                    if (tmr_done) begin
                        led_next = 1'b0;
                        top_next = TOP_OPERATE;
                    end
                end
                TOP_OPERATE: begin
                    unique case (bl_reg)
                        BL_IDLE: begin
                            led_next = 1'b0;
                            bl_next  = BL_LED_ON;
                            cnt_next = '0;
                        end
                        BL_LED_ON: begin
                            if (on_next != '0) begin
                                led_next      = 1'b1;
                                tmr_ctl.load  = 1'b1;
                                tmr_ctl.value = on_next;
                                bl_next       = BL_ON_WAIT;
                            end
                        end
                        BL_ON_WAIT: begin
                            if (tmr_done && off_next != '0) begin
                                led_next      = 1'b0;
                                tmr_ctl.load  = 1'b1;
                                tmr_ctl.value = off_next;
                                bl_next       = BL_OFF_WAIT;
                            end
                        end
                        BL_OFF_WAIT: begin
                            if (tmr_done) begin
                                cnt_next = cnt_inc;
                                if (cnt_inc < blinks_next) begin
                                    bl_next = BL_LED_ON;
                                end else if (long_next != '0) begin
                                    led_next      = 1'b0;
                                    tmr_ctl.load  = 1'b1;
                                    tmr_ctl.value = long_next;
                                    bl_next       = BL_LONG_WAIT;
                                end else begin
                                    bl_next = BL_IDLE;
                                end
                            end
                        end
                        BL_LONG_WAIT: begin
                            if (tmr_done) begin
                                bl_next = BL_IDLE;
                            end
                        end
                        default: bl_next = BL_IDLE;
                    endcase
                end
                default: top_next = TOP_IDLE;
            endcase
        end
        // Test mode forces the level on every item
        if (step && cfg.test_mode != TEST_NONE) begin
            led_next = cfg.test_mode[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg    <= TOP_IDLE;
            bl_reg     <= BL_IDLE;
            cnt_reg    <= '0;
            mode_reg   <= MODE_INITIAL;
            on_reg     <= RST_NORMAL_ON;
            off_reg    <= RST_NORMAL_OFF;
            blinks_reg <= RST_NORMAL_BLNK;
            long_reg   <= RST_LONG_OFF;
            led_reg    <= 1'b0;
        end else begin
            top_reg    <= top_next;
            bl_reg     <= bl_next;
            cnt_reg    <= cnt_next;
            mode_reg   <= mode_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
            blinks_reg <= blinks_next;
            long_reg   <= long_next;
            led_reg    <= led_next;
        end
    end

    assign led_level = led_next;

    a_blink_idle_before_operate: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg != TOP_OPERATE |-> bl_reg == BL_IDLE)
        else $error("blink machine left idle before operate phase");

    a_mode_set_in_operate: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg != TOP_OPERATE |-> mode_reg == MODE_INITIAL)
        else $error("mode latched before operate phase");

    a_no_poll_in_test: assert property (@(posedge aclk) disable iff (!aresetn)
        step && cfg.test_mode != TEST_NONE |=> $stable(top_reg) && $stable(bl_reg))
        else $error("sequencer stepped in test mode");

endmodule

`default_nettype wire

### rtl/led_blink_code_sequencer_core.sv
// Top level of the LED blink-code sequencer: stream ports, config registers,
// input and result registers. Depends on lbcs_pkg, lbcs_timer, lbcs_seq.
//
//   channel  ports                     beat contents
//   input    s_tvalid/s_tready         s_tuser: operation; s_tdata: fault
//   result   m_tvalid/m_tready         m_tdata: led_level
//   config   cfg_valid/cfg_ready       cfg_addr: register index; cfg_data: value
//
// One item per cycle while m_tready does not stall the result register; each item passes
// the input register, then the state update and result register.
// A stalled result register holds the input register; the input register
// still takes a new beat whenever it moves forward or is empty.
// Reset (aresetn low, synchronous) clears all control state and loads the
// register reset values; cfg_ready is always high.
`default_nettype none

module led_blink_code_sequencer_core #(
    parameter int START_TIME_MS = 50
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [0] fault
    input  wire logic [0:0]                     s_tuser,   // [0] operation
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [0] led_level
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lbcs_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [lbcs_pkg::CFG_D_W-1:0]   cfg_data
);
    import lbcs_pkg::*;

    cfg_t     cfg_reg;
    tmr_ctl_t tmr_ctl;
    logic     tmr_done;
    logic     in_valid_reg, in_op_reg, in_fault_reg;
    logic     out_valid_reg, out_led_reg;
    logic     advance, step, led_level;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_on_ms  <= RST_NORMAL_ON;
            cfg_reg.normal_off_ms <= RST_NORMAL_OFF;
            cfg_reg.normal_blinks <= RST_NORMAL_BLNK;
            cfg_reg.error_on_ms   <= RST_ERROR_ON;
            cfg_reg.error_off_ms  <= RST_ERROR_OFF;
            cfg_reg.error_blinks  <= RST_ERROR_BLNK;
            cfg_reg.long_off_ms   <= RST_LONG_OFF;
            cfg_reg.test_mode     <= TEST_NONE;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_NORMAL_ON:   cfg_reg.normal_on_ms  <= cfg_data;
                REG_NORMAL_OFF:  cfg_reg.normal_off_ms <= cfg_data;
                REG_NORMAL_BLNK: cfg_reg.normal_blinks <= cfg_data[BLINK_W-1:0];
                REG_ERROR_ON:    cfg_reg.error_on_ms   <= cfg_data;
                REG_ERROR_OFF:   cfg_reg.error_off_ms  <= cfg_data;
                REG_ERROR_BLNK:  cfg_reg.error_blinks  <= cfg_data[BLINK_W-1:0];
                REG_LONG_OFF:    cfg_reg.long_off_ms   <= cfg_data;
                REG_TEST_MODE:   cfg_reg.test_mode     <= cfg_data[TEST_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg    <= s_tuser[0];
            in_fault_reg <= s_tdata[0];
        end
    end

    lbcs_timer u_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tmr_ctl),
        .done    (tmr_done)
    );

    lbcs_seq #(
        .START_TIME_MS (START_TIME_MS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .op        (in_op_reg),
        .fault     (in_fault_reg),
        .cfg       (cfg_reg),
        .tmr_done  (tmr_done),
        .tmr_ctl   (tmr_ctl),
        .led_level (led_level)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_led_reg <= led_level;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_led_reg};

endmodule

`default_nettype wire

### tb/sv/led_level_checker.sv
// Checker for the LED blink-code sequencer: follows the config, input and result
// channels, predicts the LED level per input beat and compares results in order.
// Depends on lbcs_pkg.
`default_nettype none

module led_level_checker #(
    parameter int START_MS = 50
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [7:0]                     s_tdata,   // [0] fault
    input  wire logic [0:0]                     s_tuser,   // [0] operation
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [7:0]                     m_tdata,   // [0] led_level
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [lbcs_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [lbcs_pkg::CFG_D_W-1:0]   cfg_data,
    output int                                  fail_count,
    output int                                  due_count
);
    import lbcs_pkg::*;

    // Register copy and sequencer state
    cfg_t               regs;
    top_phase_t         top_st;
    blink_phase_t       blk_st;
    logic [BLINK_W-1:0] blinks_done;
    logic [BLINK_W-1:0] cur_cnt;
    logic [1:0]         last_mode;
    logic [TIME_W-1:0]  cur_on;
    logic [TIME_W-1:0]  cur_off;
    logic [TIME_W-1:0]  cur_gap;
    logic [TIME_W-1:0]  ms_left;
    logic               ms_done;
    logic               led;

    // LED levels still owed by the block, oldest first
    logic led_due[$];
    logic exp_led;

    task automatic reset_model();
        regs.normal_on_ms  = RST_NORMAL_ON;
        regs.normal_off_ms = RST_NORMAL_OFF;
        regs.normal_blinks = RST_NORMAL_BLNK;
        regs.error_on_ms   = RST_ERROR_ON;
        regs.error_off_ms  = RST_ERROR_OFF;
        regs.error_blinks  = RST_ERROR_BLNK;
        regs.long_off_ms   = RST_LONG_OFF;
        regs.test_mode     = TEST_NONE;
        top_st      = TOP_IDLE;
        blk_st      = BL_IDLE;
        blinks_done = '0;
        last_mode   = MODE_INITIAL;
        cur_on      = RST_NORMAL_ON;
        cur_off     = RST_NORMAL_OFF;
        cur_cnt     = RST_NORMAL_BLNK;
        cur_gap     = RST_LONG_OFF;
        ms_left     = '0;
        ms_done     = 1'b0;
        led         = 1'b0;
    endtask

    // Zero load finishes at once
    task automatic load_ms(input logic [TIME_W-1:0] ms);
        if (ms == '0) begin
            ms_done = 1'b1;
            ms_left = '0;
        end else begin
            ms_left = ms;
            ms_done = 1'b0;
        end
    endtask

    task automatic step_blink();
        case (blk_st)
            BL_IDLE: begin
                led         = 1'b0;
                blk_st      = BL_LED_ON;
                blinks_done = '0;
            end
            BL_LED_ON: begin
                // zero on time parks here, dark
                if (cur_on != '0) begin
                    led = 1'b1;
                    load_ms(cur_on);
                    blk_st = BL_ON_WAIT;
                end
            end
            BL_ON_WAIT: begin
                // zero off time parks here, lit
                if (ms_done && cur_off != '0) begin
                    led = 1'b0;
                    load_ms(cur_off);
                    blk_st = BL_OFF_WAIT;
                end
            end
            BL_OFF_WAIT: begin
                if (ms_done) begin
                    blinks_done = blinks_done + 1'b1;
                    if (blinks_done < cur_cnt) begin
                        blk_st = BL_LED_ON;
                    end else if (cur_gap != '0) begin
                        led = 1'b0;
                        load_ms(cur_gap);
                        blk_st = BL_LONG_WAIT;
                    end else begin
                        blk_st = BL_IDLE;
                    end
                end
            end
            BL_LONG_WAIT: begin
                if (ms_done) blk_st = BL_IDLE;
            end
            default: ;
        endcase
    endtask

    task automatic take_poll(input logic flt);
        logic [1:0] mode_now;
        case (top_st)
            TOP_IDLE: begin
                led    = 1'b1;
                top_st = TOP_START;
            end
            TOP_START: begin
                led = 1'b1;
                load_ms(START_MS[TIME_W-1:0]);
                top_st = TOP_START_WAIT;
            end
            TOP_START_WAIT: begin
                if (ms_done) begin
                    led    = 1'b0;
                    top_st = TOP_OPERATE;
                end
            end
            default: begin
                // latch timings only when the mode changes
                mode_now = flt ? MODE_FAULT : MODE_NORMAL;
                if (mode_now != last_mode) begin
                    last_mode = mode_now;
                    if (flt) begin
                        cur_cnt = regs.error_blinks;
                        cur_on  = regs.error_on_ms;
                        cur_off = regs.error_off_ms;
                    end else begin
                        cur_cnt = regs.normal_blinks;
                        cur_on  = regs.normal_on_ms;
                        cur_off = regs.normal_off_ms;
                    end
                    cur_gap = regs.long_off_ms;
                end
                step_blink();
            end
        endcase
    endtask

    // LED level after one input beat
    task automatic advance_led(input logic op, input logic flt);
        if (op == OP_TICK) begin
            if (ms_left != '0) begin
                ms_left = ms_left - 1'b1;
                ms_done = (ms_left == '0);
            end
        end else if (regs.test_mode == TEST_NONE) begin
            take_poll(flt);
        end
        // forced level sticks after test mode is cleared
        if (regs.test_mode != TEST_NONE) led = regs.test_mode[1];
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            led_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_NORMAL_ON:   regs.normal_on_ms  = cfg_data;
                    REG_NORMAL_OFF:  regs.normal_off_ms = cfg_data;
                    REG_NORMAL_BLNK: regs.normal_blinks = cfg_data[BLINK_W-1:0];
                    REG_ERROR_ON:    regs.error_on_ms   = cfg_data;
                    REG_ERROR_OFF:   regs.error_off_ms  = cfg_data;
                    REG_ERROR_BLNK:  regs.error_blinks  = cfg_data[BLINK_W-1:0];
                    REG_LONG_OFF:    regs.long_off_ms   = cfg_data;
                    REG_TEST_MODE:   regs.test_mode     = cfg_data[TEST_W-1:0];
                    default: ;
                endcase
            end

            // result beat against oldest expectation
            if (m_tvalid && m_tready) begin
                if (led_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    $error("led_level: expected none, actual %0d", m_tdata[0]);
                end else begin
                    exp_led = led_due.pop_front();
                    if (m_tdata[0] !== exp_led) begin
                        fail_count = fail_count + 1;
                        $error("led_level: expected %0d, actual %0d", exp_led, m_tdata[0]);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                advance_led(s_tuser[0], s_tdata[0]);
                led_due.push_back(led);
            end
        end
        due_count = led_due.size();
    end

endmodule

`default_nettype wire

### tb/sv/tb_led_blink_code_sequencer_core.sv
// Testbench top for led_blink_code_sequencer_core: clock, reset, config writes,
// poll/tick stimulus and result back-pressure. Depends on lbcs_pkg, led_level_checker.
`default_nettype none

module tb_led_blink_code_sequencer_core;
    import lbcs_pkg::*;

    localparam int START_MS    = 50;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 116;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    wire                 s_tready;
    logic [7:0]          s_tdata   = '0;   // [0] fault
    logic [0:0]          s_tuser   = '0;   // [0] operation
    wire                 m_tvalid;
    logic                m_tready  = 1'b0;
    wire  [7:0]          m_tdata;          // [0] led_level
    logic                cfg_valid = 1'b0;
    wire                 cfg_ready;
    logic [CFG_A_W-1:0]  cfg_addr  = '0;
    logic [CFG_D_W-1:0]  cfg_data  = '0;

    int   send_gap_pct = 20;
    int   take_gap_pct = 76;
    int   fail_count;
    int   due_count;
    logic fault_now = 1'b0;

    led_blink_code_sequencer_core #(
        .START_TIME_MS (START_MS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    led_level_checker #(
        .START_MS (START_MS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= take_gap_pct);
    end

    // run limit
    initial begin
        #2000000;
        $display("led_blink_code_sequencer_core: mismatch");
        $finish;
    end

    // valid stays high across back-to-back writes; caller drops it
    task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic send_item(input logic op, input logic flt);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, flt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (due_count != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // short timings keep the blink machine moving
    function automatic logic [TIME_W-1:0] pick_ms(input int hi);
        return TIME_W'($urandom_range(hi));
    endfunction

    task automatic load_settings(input int p);
        logic [TIME_W-1:0]  on_n;
        logic [TIME_W-1:0]  off_n;
        logic [TIME_W-1:0]  on_e;
        logic [TIME_W-1:0]  off_e;
        logic [TIME_W-1:0]  gap;
        logic [BLINK_W-1:0] cnt_n;
        logic [BLINK_W-1:0] cnt_e;
        logic [TEST_W-1:0]  tm;
        logic [CFG_D_W-1:0] junk;
        junk  = CFG_D_W'($urandom);
        on_n  = pick_ms(4);
        off_n = pick_ms(4);
        on_e  = pick_ms(4);
        off_e = pick_ms(4);
        gap   = pick_ms(6);
        cnt_n = BLINK_W'($urandom_range(4));
        cnt_e = BLINK_W'($urandom_range(4));
        tm    = TEST_NONE;
        case (p)
            0: begin
                on_n = 2; off_n = 1; cnt_n = 3;
                on_e = 1; off_e = 2; cnt_e = 1;
                gap  = 3;
            end
            1: begin
                // normal mode stalls in the on wait, single-blink groups, no dark gap
                on_n = 1; off_n = 0; cnt_n = 0;
                on_e = 2; off_e = 1; cnt_e = 0;
                gap  = 0;
            end
            2: begin
                on_n = 0; off_n = 1; cnt_n = 8'hFF;
                on_e = 1; off_e = 1; cnt_e = 8'hFF;
                gap  = 2;
            end
            3: tm = TEST_FORCE_OFF;
            4: tm = TEST_FORCE_ON;
            5: tm = TEST_FORCE_OFF | TEST_FORCE_ON;
            N_PHASES - 1: begin
                // full-scale timers park the machine for good, so last
                on_n = 16'hFFFF; off_n = 16'hFFFF; cnt_n = 8'hFF;
                on_e = 16'hFFFF; off_e = 16'hFFFF; cnt_e = 8'hFF;
                gap  = 16'hFFFF;
            end
            default: ;
        endcase
        cfg_write(REG_NORMAL_ON,   on_n);
        cfg_write(REG_NORMAL_OFF,  off_n);
        cfg_write(REG_NORMAL_BLNK, {junk[15:8], cnt_n});
        cfg_write(REG_ERROR_ON,    on_e);
        cfg_write(REG_ERROR_OFF,   off_e);
        cfg_write(REG_ERROR_BLNK,  {junk[7:0], cnt_e});
        cfg_write(REG_LONG_OFF,    gap);
        cfg_write(REG_TEST_MODE,   {junk[15:2], tm});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int   i;
        int   p;
        int   flip_pct;
        logic op;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // power-up sequence and opening operate steps at reset settings
        send_item(OP_TICK, 1'b0);   // tick with timer already empty
        send_item(OP_POLL, 1'b0);   // LED lights
        send_item(OP_POLL, 1'b1);   // start timer loaded
        send_item(OP_POLL, 1'b0);   // timer not yet done
        for (i = 0; i < START_MS; i++) send_item(OP_TICK, i[0]);
        send_item(OP_TICK, 1'b1);   // empty timer, done holds
        send_item(OP_POLL, 1'b0);   // operate, LED off
        send_item(OP_POLL, 1'b0);   // normal latched, zero on time
        send_item(OP_POLL, 1'b0);   // parked dark
        send_item(OP_POLL, 1'b1);   // fault latched, LED on
        send_item(OP_POLL, 1'b0);
        send_item(OP_POLL, 1'b1);

        for (p = 0; p < N_PHASES; p++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            if (p < 4) begin
                send_gap_pct = 20;
                take_gap_pct = 76;
            end else if (p < 8) begin
                send_gap_pct = 76;
                take_gap_pct = 20;
            end else begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            load_settings(p);
            // every third phase flips the fault flag often
            flip_pct = (p % 3 == 2) ? 25 : 4;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                op = ($urandom_range(99) < 60) ? OP_TICK : OP_POLL;
                if ($urandom_range(99) < flip_pct) fault_now = ~fault_now;
                send_item(op, fault_now);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("led_blink_code_sequencer_core: match");
        end else begin
            $display("led_blink_code_sequencer_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
